// File: rtl/stable_priority_queue_macros.svh
// Assertion macros used by the stable priority queue datapath.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spq assertion failed");
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/spq_pkg.sv
// Types and constants of the stable priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 31;
    localparam int PRI_W       = 4;
    localparam int OCC_W       = 5;

    typedef enum logic {
        FN_ENQUEUE = 1'b0,
        FN_DEQUEUE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef struct packed {
        logic    enq;
        logic    deq;
        logic    capture;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_flags;

endpackage

// File: rtl/spq_ctrl.sv
// Handshake controller of the stable priority queue.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_func  i_func,
    input  t_flags i_flags,
    output t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_HOLD = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_out_valid = (r_state == S_HOLD);
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.capture = accept;
        o_cmd.enq     = accept && (i_func == FN_ENQUEUE) && !i_flags.full;
        o_cmd.deq     = accept && (i_func == FN_DEQUEUE) && !i_flags.empty;
        if (i_func == FN_ENQUEUE) begin
            o_cmd.status = i_flags.full ? ST_FULL : ST_ENQUEUED;
        end else begin
            o_cmd.status = i_flags.empty ? ST_EMPTY : ST_DISPATCHED;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!accept && i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/spq_datapath.sv
// Sorted cell array, entry count and result register of the stable priority queue.
`include "stable_priority_queue_macros.svh"

module spq_datapath
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [ID_W-1:0]  i_proc_id,
    input  logic [PRI_W-1:0] i_priority_req,
    output t_flags           o_flags,
    output logic [1:0]       o_status,
    output logic [ID_W-1:0]  o_out_id,
    output logic [PRI_W-1:0] o_out_priority,
    output logic [OCC_W-1:0] o_occupancy
);

    logic [ID_W-1:0]  r_id  [QUEUE_DEPTH];
    logic [PRI_W-1:0] r_pri [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [QUEUE_DEPTH-1:0] at_or_after;

    t_status          r_res_status;
    logic [ID_W-1:0]  r_res_id;
    logic [PRI_W-1:0] r_res_pri;
    logic [OCC_W-1:0] r_res_occ;

    assign o_flags.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);

    // A cell lies at or after the insertion point when it is unused or holds a lower priority.
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [ID_W-1:0]  n_id;
            logic [PRI_W-1:0] n_pri;

            assign at_or_after[g] = (CNT_W'(g) >= r_count) || (r_pri[g] < i_priority_req);

            always_comb begin
                n_id  = r_id[g];
                n_pri = r_pri[g];
                if (i_cmd.enq && at_or_after[g]) begin
                    if (g == 0) begin
                        n_id  = i_proc_id;
                        n_pri = i_priority_req;
                    end else if (!at_or_after[(g == 0) ? 0 : g - 1]) begin
                        n_id  = i_proc_id;
                        n_pri = i_priority_req;
                    end else begin
                        n_id  = r_id[(g == 0) ? 0 : g - 1];
                        n_pri = r_pri[(g == 0) ? 0 : g - 1];
                    end
                end else if (i_cmd.deq && (g < QUEUE_DEPTH - 1)) begin
                    n_id  = r_id[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    n_pri = r_pri[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                end
            end

            always_ff @(posedge i_clk) begin
                r_id[g]  <= n_id;
                r_pri[g] <= n_pri;
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_cmd.enq) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res_status <= i_cmd.status;
            r_res_id     <= i_cmd.deq ? r_id[0] : '0;
            r_res_pri    <= i_cmd.deq ? r_pri[0] : '0;
            r_res_occ    <= OCC_W'(n_count);
        end
    end

    assign o_status       = r_res_status;
    assign o_out_id       = r_res_id;
    assign o_out_priority = r_res_pri;
    assign o_occupancy    = r_res_occ;

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT(a_one_op, i_clk, i_rst_n, !(i_cmd.enq && i_cmd.deq))
    `SPQ_ASSERT(a_head_sorted, i_clk, i_rst_n, (r_count < CNT_W'(2)) || (r_pri[0] >= r_pri[1]))
    `SPQ_ASSERT_NEXT(a_deq_count, i_clk, i_rst_n, i_cmd.deq, r_count == $past(r_count) - 1'b1)

endmodule

// File: rtl/stable_priority_queue.sv
// Top level of the stable priority queue.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_func, i_proc_id, i_priority_req
// result    out        o_out_valid / i_out_ready o_status, o_out_id, o_out_priority, o_occupancy
//
// Each transaction is applied to the cell array at the edge that accepts it, and its result is
// captured in the output register at that same edge; one transaction a cycle is sustained while i_out_ready is high.
// The insertion point is found by a parallel compare in every cell of the array.
// Reset is synchronous and clears the entry count and the handshake state only.
// A stalled result holds the output register, and a new transaction is taken in the
// same cycle that the held result is taken.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_func,
    input  logic [ID_W-1:0]  i_proc_id,
    input  logic [PRI_W-1:0] i_priority_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [ID_W-1:0]  o_out_id,
    output logic [PRI_W-1:0] o_out_priority,
    output logic [OCC_W-1:0] o_occupancy
);

    t_cmd   cmd;
    t_flags flags;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_func      (t_func'(i_func)),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    spq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_proc_id      (i_proc_id),
        .i_priority_req (i_priority_req),
        .o_flags        (flags),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

endmodule

// File: dv/testbench.sv
// Testbench of the stable priority queue: directed table, then random traffic against a predictor.
`timescale 1ns / 100ps

module testbench
    import spq_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 20;
    localparam int PHASE_ITEMS = 40;

    typedef struct packed {
        t_status          st;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [OCC_W-1:0] occ;
    } t_queue_result;

    typedef struct packed {
        t_func            fn;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic             typed;
        t_queue_result    res;
    } t_directed_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_func = 1'b0;
    logic [ID_W-1:0]  i_proc_id = '0;
    logic [PRI_W-1:0] i_priority_req = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_status;
    logic [ID_W-1:0]  o_out_id;
    logic [PRI_W-1:0] o_out_priority;
    logic [OCC_W-1:0] o_occupancy;

    logic [ID_W-1:0]  ready_ids [QUEUE_DEPTH];
    logic [PRI_W-1:0] ready_pris [QUEUE_DEPTH];
    int               ready_count = 0;

    t_queue_result    expected_results [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               burst_left = 0;
    int               n_enqueued = 0;
    int               n_dispatched = 0;
    int               n_empty = 0;
    int               n_refused = 0;

    t_directed_row dir_rows [0:N_DIRECTED-1] = '{
        '{FN_DEQUEUE, 31'h0,        4'd0,  1'b1, '{ST_EMPTY,    31'h0, 4'd0, 5'd0}},
        '{FN_ENQUEUE, 31'h7FFFFFFF, 4'd10, 1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd1}},
        '{FN_ENQUEUE, 31'h0,        4'd1,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd2}},
        '{FN_ENQUEUE, 31'h2AAAAAAA, 4'd5,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd3}},
        '{FN_ENQUEUE, 31'h55555555, 4'd5,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd4}},
        '{FN_ENQUEUE, 31'h1,        4'd0,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd5}},
        '{FN_ENQUEUE, 31'h2,        4'd15, 1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd6}},
        '{FN_ENQUEUE, 31'h3,        4'd10, 1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd7}},
        '{FN_ENQUEUE, 31'h4,        4'd3,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd8}},
        '{FN_ENQUEUE, 31'h5,        4'd7,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd9}},
        '{FN_ENQUEUE, 31'h6,        4'd5,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd10}},
        '{FN_ENQUEUE, 31'h7,        4'd1,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd11}},
        '{FN_ENQUEUE, 31'h8,        4'd9,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd12}},
        '{FN_ENQUEUE, 31'h9,        4'd2,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd13}},
        '{FN_ENQUEUE, 31'hA,        4'd8,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd14}},
        '{FN_ENQUEUE, 31'hB,        4'd6,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd15}},
        '{FN_ENQUEUE, 31'hC,        4'd4,  1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd16}},
        '{FN_ENQUEUE, 31'h7FFFFFFF, 4'd15, 1'b1, '{ST_FULL,     31'h0, 4'd0, 5'd16}},
        '{FN_DEQUEUE, 31'h7FFFFFFF, 4'd15, 1'b0, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd0}},
        '{FN_DEQUEUE, 31'h0,        4'd0,  1'b0, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd0}},
        '{FN_DEQUEUE, 31'h12345678, 4'd3,  1'b0, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd0}},
        '{FN_DEQUEUE, 31'h0,        4'd0,  1'b0, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd0}},
        '{FN_DEQUEUE, 31'h0,        4'd0,  1'b0, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd0}},
        '{FN_DEQUEUE, 31'h0,        4'd0,  1'b0, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd0}},
        '{FN_ENQUEUE, 31'hD,        4'd11, 1'b1, '{ST_ENQUEUED, 31'h0, 4'd0, 5'd11}}
    };

    stable_priority_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_proc_id      (i_proc_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        case ((cycle_count / 97) % 4)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            2: i_out_ready <= (cycle_count % 4 == 0);
            default: i_out_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    function automatic t_queue_result predict_queue_op(input t_func fn,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [PRI_W-1:0] pri);
        t_queue_result res;
        int            pos;
        res = '{ST_ENQUEUED, '0, '0, '0};
        if (fn == FN_ENQUEUE) begin
            if (ready_count >= QUEUE_DEPTH) begin
                res.st = ST_FULL;
            end else begin
                pos = ready_count;
                for (int i = ready_count - 1; i >= 0; i--) begin
                    if (ready_pris[i] < pri) pos = i;
                end
                for (int i = ready_count; i > pos; i--) begin
                    ready_ids[i]  = ready_ids[i-1];
                    ready_pris[i] = ready_pris[i-1];
                end
                ready_ids[pos]  = id;
                ready_pris[pos] = pri;
                ready_count++;
            end
        end else if (ready_count == 0) begin
            res.st = ST_EMPTY;
        end else begin
            res.st  = ST_DISPATCHED;
            res.id  = ready_ids[0];
            res.pri = ready_pris[0];
            for (int i = 1; i < ready_count; i++) begin
                ready_ids[i-1]  = ready_ids[i];
                ready_pris[i-1] = ready_pris[i];
            end
            ready_count--;
        end
        res.occ = ready_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic send_item(input t_func fn, input logic [ID_W-1:0] id,
                             input logic [PRI_W-1:0] pri, input logic typed,
                             input t_queue_result typed_res);
        int            idle_len;
        t_queue_result res;
        idle_len = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) idle_len = $urandom_range(1, 6);
        end
        burst_left--;
        if (idle_len > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle_len) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= fn;
        i_proc_id      <= id;
        i_priority_req <= pri;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        res = predict_queue_op(fn, id, pri);
        expected_results.push_back(typed ? typed_res : res);
    endtask

    always @(posedge i_clk) begin
        t_queue_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d id %0h", $time,
                         o_status, o_out_id);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_res.st,
                             o_status);
                    error_count++;
                end
                if (o_out_id !== exp_res.id) begin
                    $display("%0t: id expected %0h actual %0h", $time, exp_res.id, o_out_id);
                    error_count++;
                end
                if (o_out_priority !== exp_res.pri) begin
                    $display("%0t: priority expected %0d actual %0d", $time, exp_res.pri,
                             o_out_priority);
                    error_count++;
                end
                if (o_occupancy !== exp_res.occ) begin
                    $display("%0t: occupancy expected %0d actual %0d", $time, exp_res.occ,
                             o_occupancy);
                    error_count++;
                end
                case (exp_res.st)
                    ST_ENQUEUED:   n_enqueued++;
                    ST_DISPATCHED: n_dispatched++;
                    ST_EMPTY:      n_empty++;
                    default:       n_refused++;
                endcase
            end
        end
    end

    initial begin
        int               enq_pct;
        bit               narrow;
        t_func            fn;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        int               pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(dir_rows[r].fn, dir_rows[r].id, dir_rows[r].pri, dir_rows[r].typed,
                      dir_rows[r].res);
        end

        // Most phases lean towards filling or draining, so both full and empty are reached often.
        for (int p = 0; p < N_PHASES; p++) begin
            enq_pct = 10 + 20 * $urandom_range(0, 4);
            narrow  = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                fn   = ($urandom_range(0, 99) < enq_pct) ? FN_ENQUEUE : FN_DEQUEUE;
                id   = ID_W'($urandom);
                pick = $urandom_range(0, 19);
                if (pick == 0) id = '0;
                else if (pick == 1) id = '1;
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    pri = narrow ? PRI_W'($urandom_range(1, 3)) : PRI_W'($urandom_range(1, 10));
                end else begin
                    pri = PRI_W'($urandom_range(0, 15));
                end
                send_item(fn, id, pri, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Covered %0d enqueues, %0d dispatches, %0d empty dequeues, %0d refusals.",
                 n_enqueued, n_dispatched, n_empty, n_refused);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
